// File: rtl/ttab_pkg.sv
// Shared types and constants for the timer table engine.
package ttab_pkg;

    localparam int NUM_TIMERS   = 32;
    localparam int SLOT_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int RESULT_LIMIT = 32;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // Input command kinds.
    localparam logic [2:0] K_CREATE       = 3'd0;
    localparam logic [2:0] K_CREATE_START = 3'd1;
    localparam logic [2:0] K_RESCHED_P    = 3'd2;
    localparam logic [2:0] K_RESCHED_O    = 3'd3;
    localparam logic [2:0] K_CANCEL       = 3'd4;
    localparam logic [2:0] K_KILL         = 3'd5;
    localparam logic [2:0] K_QUERY        = 3'd6;
    localparam logic [2:0] K_TICK         = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_TMR  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_ARG = 2'd3;

    // Operations broadcast to the cells.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CREATE,
        OP_RESCHED_P,
        OP_RESCHED_O,
        OP_CANCEL,
        OP_KILL,
        OP_FIRE,
        OP_TICK_CLR
    } op_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        gen;
        logic               start;
        logic [31:0]        ival;
        logic               given;
        logic [63:0]        expire;
        logic [63:0]        now;
    } cmd_t;

    // Search token that travels along the row of cells.
    typedef struct packed {
        logic               valid;
        logic               mode_free;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [15:0]        gen;
        logic [63:0]        deadline;
    } tok_t;

    // Read-out of the addressed slot.
    typedef struct packed {
        logic               used;
        logic [15:0]        gen;
        logic               sched;
        logic               rep;
        logic [31:0]        period;
    } rd_t;

endpackage

// File: rtl/ttab_cell.sv
// One timer slot: its state, its command decode and one stage of the search chain.
module ttab_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ttab_pkg::SLOT_W-1:0] idx,
    input  ttab_pkg::cmd_t              cmd,
    input  ttab_pkg::tok_t              tok_in,
    output ttab_pkg::tok_t              tok_out,
    output ttab_pkg::rd_t               rd
);

    logic        used_reg;
    logic        sched_reg;
    logic        rep_reg;
    logic        done_reg;
    logic [15:0] gen_reg;
    logic [31:0] period_reg;
    logic [63:0] deadline_reg;
    logic        tok_valid_reg;
    ttab_pkg::tok_t tok_reg;
    ttab_pkg::tok_t tok_next;

    logic        hit;
    logic        due;
    logic        cand;
    logic        take;
    logic [63:0] diff;
    logic [31:0] per_resched;

    assign hit         = (cmd.slot == idx);
    assign diff        = cmd.now - deadline_reg;
    assign due         = ~diff[63];
    assign per_resched = cmd.given ? cmd.ival : period_reg;

    // Control bits of the slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            sched_reg <= 1'b0;
            rep_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (cmd.op == ttab_pkg::OP_TICK_CLR)
        begin
            done_reg <= 1'b0;
        end
        else if (hit)
        begin
            unique case (cmd.op)
                ttab_pkg::OP_CREATE:
                begin
                    used_reg  <= 1'b1;
                    sched_reg <= cmd.start;
                    rep_reg   <= cmd.given && !(cmd.start && cmd.expire != 64'd0);
                end
                ttab_pkg::OP_RESCHED_P:
                begin
                    rep_reg   <= 1'b1;
                    sched_reg <= 1'b1;
                end
                ttab_pkg::OP_RESCHED_O:
                begin
                    rep_reg   <= 1'b0;
                    sched_reg <= 1'b1;
                end
                ttab_pkg::OP_CANCEL:
                begin
                    sched_reg <= 1'b0;
                end
                ttab_pkg::OP_KILL:
                begin
                    sched_reg <= 1'b0;
                    used_reg  <= 1'b0;
                    rep_reg   <= 1'b0;
                end
                ttab_pkg::OP_FIRE:
                begin
                    done_reg <= 1'b1;
                    if (!rep_reg)
                    begin
                        sched_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload of the slot: generation, period and deadline.
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            unique case (cmd.op)
                ttab_pkg::OP_CREATE:
                begin
                    gen_reg    <= cmd.gen;
                    period_reg <= cmd.given ? cmd.ival : 32'd0;
                    if (cmd.expire != 64'd0)
                    begin
                        deadline_reg <= cmd.expire;
                    end
                    else
                    begin
                        deadline_reg <= cmd.now + {32'd0, cmd.ival};
                    end
                end
                ttab_pkg::OP_RESCHED_P:
                begin
                    period_reg   <= per_resched;
                    deadline_reg <= cmd.now + {32'd0, per_resched};
                end
                ttab_pkg::OP_RESCHED_O:
                begin
                    deadline_reg <= cmd.expire;
                end
                ttab_pkg::OP_FIRE:
                begin
                    if (rep_reg)
                    begin
                        deadline_reg <= deadline_reg + {32'd0, period_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Search stage: keep the earlier candidate, or the first free slot.
    assign cand = tok_in.mode_free ? !used_reg
                                   : (used_reg && sched_reg && !done_reg && due);
    assign take = cand && (!tok_in.found ||
                           (!tok_in.mode_free && deadline_reg < tok_in.deadline));

    always_comb
    begin
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.slot     = idx;
            tok_next.gen      = gen_reg;
            tok_next.deadline = deadline_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    // Read-out of this slot when it is addressed.
    always_comb
    begin
        rd = '0;
        if (hit)
        begin
            rd.used   = used_reg;
            rd.gen    = gen_reg;
            rd.sched  = sched_reg;
            rd.rep    = rep_reg;
            rd.period = period_reg;
        end
    end

endmodule

// File: rtl/ttab_row.sv
// Row of timer cells chained for searching, with the read-out of the addressed slot.
module ttab_row (
    input  logic            clk,
    input  logic            rst_n,
    input  ttab_pkg::cmd_t  cmd,
    input  ttab_pkg::tok_t  tok_head,
    output ttab_pkg::tok_t  tok_tail,
    output ttab_pkg::rd_t   rd
);

    ttab_pkg::tok_t tok [ttab_pkg::NUM_TIMERS+1];
    ttab_pkg::rd_t  rd_cell [ttab_pkg::NUM_TIMERS];

    assign tok[0] = tok_head;

    for (genvar g = 0; g < ttab_pkg::NUM_TIMERS; g++)
    begin : g_cell
        ttab_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (ttab_pkg::SLOT_W'(g)),
            .cmd     (cmd),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .rd      (rd_cell[g])
        );
    end

    assign tok_tail = tok[ttab_pkg::NUM_TIMERS];

    // Only the addressed cell drives a nonzero read-out.
    always_comb
    begin
        rd = '0;
        for (int i = 0; i < ttab_pkg::NUM_TIMERS; i++)
        begin
            rd = rd | rd_cell[i];
        end
    end

endmodule

// File: rtl/timer_table_engine_top.sv
// Top level of the timer table engine: command sequencer, result register and cell row.
// Any command but create or tick is decided in the exec state into the result register.
// A create passes one search through the NUM_TIMERS cells and then shows its result.
// A tick runs one search per fired timer, plus a closing search unless the limit is hit,
// and puts out one result per fired timer; one item is in work at a time.
// Reset clears slot usage, scheduling and the generation counter (restarts at one).
module timer_table_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] handle,
    input  logic [31:0] interval,
    input  logic        interval_given,
    input  logic [63:0] expiry,
    input  logic [63:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] timer_handle,
    output logic [31:0] period,
    output logic        is_periodic,
    output logic        is_active,
    output logic        fired,
    output logic        last
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WAIT   = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] hdl;
        logic [31:0] period;
        logic        isp;
        logic        act;
        logic        fired;
        logic        last;
    } res_t;

    localparam logic [ttab_pkg::CNT_W-1:0] CNT_LIMIT =
        ttab_pkg::CNT_W'(ttab_pkg::RESULT_LIMIT);

    function automatic res_t mk_res(input logic [1:0] st, input logic [31:0] h,
                                    input logic f, input logic l);
        res_t r;
        r        = '0;
        r.status = st;
        r.hdl    = h;
        r.fired  = f;
        r.last   = l;
        return r;
    endfunction

    state_t      state_reg;
    state_t      state_next;
    res_t        res_reg;
    res_t        res_next;
    logic        ret_launch_reg;
    logic        ret_launch_next;
    logic        flush_reg;
    logic        flush_next;
    logic        pend_v_reg;
    logic        pend_v_next;
    logic [31:0] pend_hdl_reg;
    logic [31:0] pend_hdl_next;
    logic [ttab_pkg::CNT_W-1:0] n_reg;
    logic [ttab_pkg::CNT_W-1:0] n_next;
    logic [15:0] next_gen_reg;
    logic [15:0] next_gen_next;

    logic [2:0]  kind_reg;
    logic [31:0] handle_reg;
    logic [31:0] ival_reg;
    logic        given_reg;
    logic [63:0] expire_reg;
    logic [63:0] now_reg;

    ttab_pkg::cmd_t cmd;
    ttab_pkg::tok_t tok_head;
    ttab_pkg::tok_t tok_tail;
    ttab_pkg::rd_t  rd;

    logic        bad_ival;
    logic        in_range;
    logic        found;
    logic        is_create;
    logic [31:0] fire_hdl;
    logic [ttab_pkg::CNT_W-1:0] n_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    assign status       = res_reg.status;
    assign timer_handle = res_reg.hdl;
    assign period       = res_reg.period;
    assign is_periodic  = res_reg.isp;
    assign is_active    = res_reg.act;
    assign fired        = res_reg.fired;
    assign last         = res_reg.last;

    assign bad_ival  = given_reg && ival_reg[31];
    assign in_range  = (handle_reg[15:0] < 16'(ttab_pkg::NUM_TIMERS));
    assign found     = in_range && rd.used && (handle_reg[31:16] != 16'd0)
                       && (rd.gen == handle_reg[31:16]);
    assign is_create = (kind_reg == ttab_pkg::K_CREATE)
                    || (kind_reg == ttab_pkg::K_CREATE_START);
    assign fire_hdl  = {tok_tail.gen, 16'(tok_tail.slot)};
    assign n_inc     = n_reg + 1'b1;

    // Search token entering the row.
    always_comb
    begin
        tok_head           = '0;
        tok_head.valid     = (state_reg == S_LAUNCH);
        tok_head.mode_free = is_create;
    end

    // Command broadcast to the cells.
    always_comb
    begin
        cmd        = '0;
        cmd.op     = ttab_pkg::OP_NONE;
        cmd.slot   = handle_reg[ttab_pkg::SLOT_W-1:0];
        cmd.gen    = next_gen_reg;
        cmd.start  = (kind_reg == ttab_pkg::K_CREATE_START);
        cmd.ival   = ival_reg;
        cmd.given  = given_reg;
        cmd.expire = expire_reg;
        cmd.now    = now_reg;
        if (state_reg == S_EXEC)
        begin
            if (kind_reg == ttab_pkg::K_TICK)
            begin
                cmd.op = ttab_pkg::OP_TICK_CLR;
            end
            else if (found && !is_create)
            begin
                priority if (kind_reg == ttab_pkg::K_RESCHED_P)
                begin
                    if (!bad_ival && (given_reg || rd.rep))
                    begin
                        cmd.op = ttab_pkg::OP_RESCHED_P;
                    end
                end
                else if (kind_reg == ttab_pkg::K_RESCHED_O)
                begin
                    if (expire_reg != 64'd0)
                    begin
                        cmd.op = ttab_pkg::OP_RESCHED_O;
                    end
                end
                else if (kind_reg == ttab_pkg::K_CANCEL)
                begin
                    cmd.op = ttab_pkg::OP_CANCEL;
                end
                else if (kind_reg == ttab_pkg::K_KILL)
                begin
                    cmd.op = ttab_pkg::OP_KILL;
                end
                else
                begin
                    cmd.op = ttab_pkg::OP_NONE;
                end
            end
        end
        else if (state_reg == S_WAIT && tok_tail.valid && tok_tail.found)
        begin
            cmd.slot = tok_tail.slot;
            cmd.op   = is_create ? ttab_pkg::OP_CREATE : ttab_pkg::OP_FIRE;
        end
    end

    ttab_row u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .tok_head (tok_head),
        .tok_tail (tok_tail),
        .rd       (rd)
    );

    // Latch the input transaction.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg   <= kind;
            handle_reg <= handle;
            ival_reg   <= interval;
            given_reg  <= interval_given;
            expire_reg <= expiry;
            now_reg    <= now;
        end
    end

    // Sequencer: next state and result.
    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        ret_launch_next = ret_launch_reg;
        flush_next      = flush_reg;
        pend_v_next     = pend_v_reg;
        pend_hdl_next   = pend_hdl_reg;
        n_next          = n_reg;
        next_gen_next   = next_gen_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ret_launch_next = 1'b0;
                flush_next      = 1'b0;
                state_next      = S_OUT;
                if (kind_reg == ttab_pkg::K_TICK)
                begin
                    n_next      = '0;
                    pend_v_next = 1'b0;
                    state_next  = S_LAUNCH;
                end
                else if (is_create)
                begin
                    if (bad_ival || (cmd.start && !given_reg && expire_reg == 64'd0))
                    begin
                        res_next = mk_res(ttab_pkg::ST_BAD_ARG, 32'd0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        state_next = S_LAUNCH;
                    end
                end
                else if (kind_reg == ttab_pkg::K_RESCHED_O && expire_reg == 64'd0)
                begin
                    res_next = mk_res(ttab_pkg::ST_BAD_ARG, 32'd0, 1'b0, 1'b1);
                end
                else if (!found)
                begin
                    res_next = mk_res(ttab_pkg::ST_NO_TMR, 32'd0, 1'b0, 1'b1);
                end
                else if (kind_reg == ttab_pkg::K_RESCHED_P
                         && (bad_ival || (!given_reg && !rd.rep)))
                begin
                    res_next = mk_res(ttab_pkg::ST_BAD_ARG, 32'd0, 1'b0, 1'b1);
                end
                else if (kind_reg == ttab_pkg::K_QUERY)
                begin
                    res_next        = mk_res(ttab_pkg::ST_OK, handle_reg, 1'b0, 1'b1);
                    res_next.period = rd.rep ? rd.period : 32'hFFFF_FFFF;
                    res_next.isp    = rd.rep;
                    res_next.act    = rd.sched;
                end
                else
                begin
                    res_next = mk_res(ttab_pkg::ST_OK, 32'd0, 1'b0, 1'b1);
                end
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (tok_tail.valid)
                begin
                    state_next      = S_OUT;
                    ret_launch_next = 1'b0;
                    flush_next      = 1'b0;
                    if (is_create)
                    begin
                        if (tok_tail.found)
                        begin
                            res_next = mk_res(ttab_pkg::ST_OK,
                                              {next_gen_reg, 16'(tok_tail.slot)},
                                              1'b0, 1'b1);
                            next_gen_next = (next_gen_reg == 16'hFFFF) ? 16'd1
                                            : next_gen_reg + 16'd1;
                        end
                        else
                        begin
                            res_next = mk_res(ttab_pkg::ST_FULL, 32'd0, 1'b0, 1'b1);
                        end
                    end
                    else if (tok_tail.found)
                    begin
                        n_next        = n_inc;
                        pend_v_next   = 1'b1;
                        pend_hdl_next = fire_hdl;
                        if (pend_v_reg)
                        begin
                            res_next = mk_res(ttab_pkg::ST_OK, pend_hdl_reg, 1'b1, 1'b0);
                            if (n_inc == CNT_LIMIT)
                            begin
                                flush_next = 1'b1;
                            end
                            else
                            begin
                                ret_launch_next = 1'b1;
                            end
                        end
                        else if (n_inc == CNT_LIMIT)
                        begin
                            res_next = mk_res(ttab_pkg::ST_OK, fire_hdl, 1'b1, 1'b1);
                        end
                        else
                        begin
                            state_next = S_LAUNCH;
                        end
                    end
                    else if (pend_v_reg)
                    begin
                        res_next = mk_res(ttab_pkg::ST_OK, pend_hdl_reg, 1'b1, 1'b1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (flush_reg)
                    begin
                        flush_next = 1'b0;
                        res_next   = mk_res(ttab_pkg::ST_OK, pend_hdl_reg, 1'b1, 1'b1);
                    end
                    else
                    begin
                        state_next = ret_launch_reg ? S_LAUNCH : S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_launch_reg <= 1'b0;
            flush_reg      <= 1'b0;
            pend_v_reg     <= 1'b0;
            n_reg          <= '0;
            next_gen_reg   <= 16'd1;
        end
        else
        begin
            state_reg      <= state_next;
            ret_launch_reg <= ret_launch_next;
            flush_reg      <= flush_next;
            pend_v_reg     <= pend_v_next;
            n_reg          <= n_next;
            next_gen_reg   <= next_gen_next;
        end
    end

    // Result and pending handle carry no reset; they are read only once written.
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        pend_hdl_reg <= pend_hdl_next;
    end

    // A search token leaves the row only while the sequencer waits for it.
    a_tok_wait: assert property (@(posedge clk) disable iff (!rst_n)
        tok_tail.valid |-> state_reg == S_WAIT)
        else $error("search token left the row outside the wait state");

    // The firing count of one tick stays within the limit.
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_LIMIT)
        else $error("tick fired more timers than the limit");

    // A result that is not the last of a tick is always followed by more work.
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (fired && (ret_launch_reg || flush_reg)))
        else $error("non-final result with nothing left to deliver");

    // The generation counter never holds zero.
    a_gen_nz: assert property (@(posedge clk) disable iff (!rst_n)
        next_gen_reg != 16'd0)
        else $error("generation counter reached zero");

endmodule
